/* rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the stack arithmetic unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next edge, switched off while reset is held
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/smau_pkg.sv */
// Shared types, codes and sizes for the stack arithmetic unit.
// No dependencies; used by smau_iter and stack_machine_arith_unit.
package smau_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_W      = 32;
  localparam int OPCODE_W    = 3;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_OUT_W = 7;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ITER_W      = $clog2(WORD_W);
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [DEPTH_W-1:0]     depth_t;
  typedef logic [DEPTH_OUT_W-1:0] depth_out_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [OPCODE_W-1:0]    opcode_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [ITER_W-1:0]      iter_cnt_t;

  // Opcodes
  localparam opcode_t OP_PUSH = 3'd0;
  localparam opcode_t OP_SUB  = 3'd1;
  localparam opcode_t OP_MUL  = 3'd2;
  localparam opcode_t OP_DIV  = 3'd3;
  localparam opcode_t OP_MOD  = 3'd4;

  // Status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_SHORT    = 3'd1;
  localparam status_t ST_DIVZERO  = 3'd2;
  localparam status_t ST_OVERFLOW = 3'd3;
  localparam status_t ST_HALTED   = 3'd4;

  // Request into the shared multiply/divide unit
  typedef struct packed {
    logic  start;
    logic  is_div;
    word_t op_a;   // dividend magnitude, or multiplier scanned from the LSB
    word_t op_b;   // divisor magnitude, or multiplicand
  } iter_req_t;

  // Response from the shared multiply/divide unit
  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quo;       // unsigned quotient
    word_t rem_prod;  // unsigned remainder, or low half of the product
  } iter_rsp_t;

endpackage

/* rtl/smau_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/smau_iter.sv */
// Shared bit-serial unit: unsigned restoring divide or shift-add multiply,
// one bit per cycle through a single adder. Depends on smau_pkg.
module smau_iter (
  input  logic                clk,
  input  logic                rst_n,
  input  smau_pkg::iter_req_t req,
  output smau_pkg::iter_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  div_r, div_nxt;
  smau_pkg::iter_cnt_t   cnt_r, cnt_nxt;
  smau_pkg::word_t       acc_r, acc_nxt;
  smau_pkg::word_t       q_r, q_nxt;
  smau_pkg::word_t       b_r, b_nxt;

  logic [smau_pkg::WORD_W:0]   add_x;
  logic [smau_pkg::WORD_W:0]   add_y;
  logic [smau_pkg::WORD_W+1:0] add_sum;
  logic                        take;

  // Shared adder: subtract in divide mode, add in multiply mode
  always_comb begin
    if (div_r) begin
      add_x = {acc_r, q_r[smau_pkg::WORD_W-1]};
    end else begin
      add_x = {1'b0, acc_r};
    end
    add_y   = {1'b0, b_r};
    add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(smau_pkg::WORD_W + 2){div_r}})
              + (smau_pkg::WORD_W + 2)'(div_r);
    take    = !add_sum[smau_pkg::WORD_W+1];
  end

  // Step sequencing
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    b_nxt    = b_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      cnt_nxt  = smau_pkg::iter_cnt_t'(smau_pkg::WORD_W - 1);
      acc_nxt  = '0;
      q_nxt    = req.op_a;
      b_nxt    = req.op_b;
    end else if (busy_r) begin
      if (div_r) begin
        acc_nxt = take ? add_sum[smau_pkg::WORD_W-1:0] : add_x[smau_pkg::WORD_W-1:0];
        q_nxt   = {q_r[smau_pkg::WORD_W-2:0], take};
      end else begin
        acc_nxt = q_r[0] ? add_sum[smau_pkg::WORD_W-1:0] : add_x[smau_pkg::WORD_W-1:0];
        q_nxt   = q_r >> 1;
        b_nxt   = b_r << 1;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quo      = q_r;
  assign rsp.rem_prod = acc_r;

endmodule

/* rtl/stack_machine_arith_unit.sv */
// Stack arithmetic unit: operand stack in RAM, cached top word, sequencer.
// Accept to result: push, errors, halted and no-op words pass S_DECODE and S_DONE;
// subtract also S_READ and S_WB; multiply/divide/modulo also S_ITER (32 steps of the
// bit-serial unit). A new word is taken in S_IDLE, once the result is registered.
// Reset (synchronous, rst_n low): empty stack, halt cleared, no result pending.
// Depends on smau_pkg, smau_ram, smau_iter and assert_macros.svh.
`include "assert_macros.svh"

module stack_machine_arith_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] opcode, [34:3] push_value, [39:35] zero
  input  logic [smau_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] status, [34:3] top_value, [41:35] depth, [47:42] zero
  output logic [smau_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_ITER   = 3'd3;
  localparam logic [2:0] S_WB     = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  smau_pkg::depth_t      depth_r, depth_nxt;
  logic                  halted_r, halted_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  smau_pkg::opcode_t     op_r, op_nxt;
  smau_pkg::word_t       val_r, val_nxt;
  smau_pkg::word_t       top_r, top_nxt;
  smau_pkg::word_t       res_r, res_nxt;
  smau_pkg::status_t     status_r, status_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_r_r, neg_r_nxt;
  smau_pkg::status_t     out_status_r, out_status_nxt;
  smau_pkg::word_t       out_top_r, out_top_nxt;
  smau_pkg::depth_out_t  out_depth_r, out_depth_nxt;

  smau_pkg::depth_t      depth_m2;
  smau_pkg::word_t       second;
  logic                  ram_we;
  smau_pkg::addr_t       ram_waddr;
  smau_pkg::word_t       ram_wdata;
  smau_pkg::word_t       ram_rdata;
  smau_pkg::iter_req_t   iter_req;
  smau_pkg::iter_rsp_t   iter_rsp;
  logic                  in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign depth_m2  = depth_r - smau_pkg::depth_t'(2);
  assign second    = ram_rdata;

  // Operand stack; the word below the top is read at depth minus two
  smau_ram #(
    .WIDTH (smau_pkg::WORD_W),
    .DEPTH (smau_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (depth_m2[smau_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Shared multiply/divide unit
  smau_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .rsp   (iter_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    halted_nxt     = halted_r;
    out_tvalid_nxt = out_tvalid_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    top_nxt        = top_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    neg_q_nxt      = neg_q_r;
    neg_r_nxt      = neg_r_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    ram_we         = 1'b0;
    ram_waddr      = depth_m2[smau_pkg::ADDR_W-1:0];
    ram_wdata      = res_r;
    iter_req       = '0;

    // result register drains independently of the sequencer
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tdata[smau_pkg::OPCODE_W-1:0];
          val_nxt   = in_tdata[smau_pkg::OPCODE_W +: smau_pkg::WORD_W];
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = smau_pkg::ST_OK;
        state_nxt  = S_DONE;
        if (halted_r) begin
          status_nxt = smau_pkg::ST_HALTED;
        end else if (op_r == smau_pkg::OP_PUSH) begin
          if (depth_r >= smau_pkg::depth_t'(smau_pkg::STACK_DEPTH)) begin
            status_nxt = smau_pkg::ST_OVERFLOW;
            halted_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = depth_r[smau_pkg::ADDR_W-1:0];
            ram_wdata = val_r;
            top_nxt   = val_r;
            depth_nxt = depth_r + 1'b1;
          end
        end else if (op_r inside {smau_pkg::OP_SUB, smau_pkg::OP_MUL,
                                  smau_pkg::OP_DIV, smau_pkg::OP_MOD}) begin
          if (depth_r < smau_pkg::depth_t'(2)) begin
            status_nxt = smau_pkg::ST_SHORT;
            halted_nxt = 1'b1;
          end else if ((op_r inside {smau_pkg::OP_DIV, smau_pkg::OP_MOD}) &&
                       top_r == '0) begin
            status_nxt = smau_pkg::ST_DIVZERO;
            halted_nxt = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // second operand now out of the RAM
        case (op_r)
          smau_pkg::OP_SUB: begin
            res_nxt   = second - top_r;
            state_nxt = S_WB;
          end
          smau_pkg::OP_MUL: begin
            iter_req.start  = 1'b1;
            iter_req.is_div = 1'b0;
            iter_req.op_a   = top_r;
            iter_req.op_b   = second;
            state_nxt       = S_ITER;
          end
          default: begin
            iter_req.start  = 1'b1;
            iter_req.is_div = 1'b1;
            iter_req.op_a   = second[smau_pkg::WORD_W-1] ? -second : second;
            iter_req.op_b   = top_r[smau_pkg::WORD_W-1] ? -top_r : top_r;
            neg_q_nxt       = second[smau_pkg::WORD_W-1] ^ top_r[smau_pkg::WORD_W-1];
            neg_r_nxt       = second[smau_pkg::WORD_W-1];
            state_nxt       = S_ITER;
          end
        endcase
      end
      S_ITER: begin
        if (iter_rsp.done) begin
          case (op_r)
            smau_pkg::OP_MUL: res_nxt = iter_rsp.rem_prod;
            smau_pkg::OP_DIV: res_nxt = neg_q_r ? -iter_rsp.quo : iter_rsp.quo;
            default:          res_nxt = neg_r_r ? -iter_rsp.rem_prod : iter_rsp.rem_prod;
          endcase
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        // result replaces the second word and becomes the top
        ram_we    = 1'b1;
        ram_waddr = depth_m2[smau_pkg::ADDR_W-1:0];
        ram_wdata = res_r;
        top_nxt   = res_r;
        depth_nxt = depth_r - 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_top_nxt    = (depth_r == '0) ? '0 : top_r;
          out_depth_nxt  = smau_pkg::depth_out_t'(depth_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      depth_r      <= '0;
      halted_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      depth_r      <= depth_nxt;
      halted_r     <= halted_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    top_r        <= top_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    neg_q_r      <= neg_q_nxt;
    neg_r_r      <= neg_r_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(smau_pkg::OUT_TDATA_W - smau_pkg::STATUS_W - smau_pkg::WORD_W
                         - smau_pkg::DEPTH_OUT_W){1'b0}},
                       out_depth_r, out_top_r, out_status_r};

  // Checks
  `ASSERT_CLK(a_depth_bound, depth_r <= smau_pkg::depth_t'(smau_pkg::STACK_DEPTH), "stack depth beyond capacity")
  `ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt flag cleared without reset")
  `ASSERT_NEXT(a_halt_frozen, halted_r, $stable(depth_r) && $stable(top_r), "stack changed while halted")
  `ASSERT_CLK(a_err_halts, !out_tvalid_r || out_status_r == smau_pkg::ST_OK || halted_r, "error word without halt")
  `ASSERT_CLK(a_iter_idle_start, !iter_req.start || !iter_rsp.busy, "multiply/divide started while busy")

endmodule
